>>> rtl/gbso_pkg.sv
// shared types, constants and the ordering function for the box suppression block
package gbso_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int COORD_BITS     = 12;
  localparam int IDX_BITS       = $clog2(MAX_CANDIDATES);
  localparam int CNT_BITS       = $clog2(MAX_CANDIDATES + 1);
  localparam int SCORE_BITS     = 16;
  localparam int PAT_BITS       = 8;
  localparam int AREA_BITS      = 2 * COORD_BITS;
  localparam int RATIO_BITS     = 16;
  localparam int MODE_BITS      = 3;
  localparam int FRAC_BITS      = 15;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 16;

  // opcodes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_ADD_PROC = 2'd1;
  localparam logic [1:0] OP_PROC     = 2'd2;
  localparam logic [1:0] OP_NOP      = 2'd3;

  // order modes
  localparam logic [MODE_BITS-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_XY    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_YX    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SCORE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_AREA  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 1'd1;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd16384;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic [SCORE_BITS-1:0] match_score;
    logic [PAT_BITS-1:0]   pattern_number;
    logic [SCORE_BITS-1:0] keep_threshold;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_w;
    logic [COORD_BITS-1:0] out_h;
    logic [SCORE_BITS-1:0] out_score;
    logic [PAT_BITS-1:0]   out_pattern;
    logic                  is_last;
    logic                  is_empty;
    logic                  overflowed;
  } out_t;

  // one stored candidate
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [SCORE_BITS-1:0] score;
    logic [PAT_BITS-1:0]   pattern;
    logic [SCORE_BITS-1:0] thresh;
    logic [AREA_BITS-1:0]  area;
    logic                  mark;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SORT,
    CMD_ROT,
    CMD_DROP,
    CMD_MARK
  } cmd_t;

  // broadcast control to the cell row
  typedef struct packed {
    cmd_t                 cmd;
    logic [MODE_BITS-1:0] mode;
    logic                 parity;
    logic [CNT_BITS-1:0]  cnt;
    entry_t               load;
  } ctl_t;

  // true when a must come ahead of b under mode
  function automatic logic goes_before(entry_t a, entry_t b, logic [MODE_BITS-1:0] mode);
    logic res;
    case (mode)
      MODE_XY:    res = (a.x != b.x) ? (a.x < b.x) : (a.y < b.y);
      MODE_YX:    res = (a.y != b.y) ? (a.y < b.y) : (a.x < b.x);
      MODE_SCORE: res = a.score > b.score;
      MODE_AREA:  res = (a.area != b.area) ? (a.area > b.area) : (a.score > b.score);
      default:    res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/greedy_box_suppress_and_order_top.sv
// top level: candidate row, sequencer for sort, suppression, filter, order and output
//
//  channel | signals                       | payload
//  input   | in_valid / in_ready           | in_data (in_t)
//  output  | out_valid / out_ready         | out_data (out_t)
//  config  | cfg_we, cfg_index, cfg_data   | overlap ratio, order mode
//
// an add leaves the block idle and ready for the next transaction.
// a process run takes n score-sort rounds and suppression (skipped for a zero ratio),
// with one shared overlap unit and the row rotating past it, n filter steps, n order-sort
// rounds in an order mode, then one result per cycle as the output is taken.
// reset is synchronous; the stored entries hold no reset, the count clears.
// a stalled output register holds the sequencer in the emit step.
module greedy_box_suppress_and_order_top import gbso_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_t                      in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_t                     out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROC, S_SSORT, S_SUP_HEAD, S_SUP_STEP,
    S_E1, S_E2, S_E3, S_E4, S_CMP, S_OSORT, S_EMIT, S_EMPTY
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   cnt, n_run, i_cnt, t_cnt;
  logic                  ovf;
  logic [RATIO_BITS-1:0] ratio;
  logic [MODE_BITS-1:0]  order_mode;
  entry_t                kept;
  entry_t                cells [MAX_CANDIDATES];
  logic                  swaps [MAX_CANDIDATES];
  ctl_t                  ctl;
  logic                  accept, is_add, head_keep, hit, load_out, emit_now;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_add    = (in_data.opcode == OP_ADD) || (in_data.opcode == OP_ADD_PROC);
  assign head_keep = !cells[0].mark && (cells[0].score >= cells[0].thresh);
  assign load_out  = (!out_valid || out_ready);
  assign emit_now  = load_out && (state == S_EMIT || state == S_EMPTY);

  // the row of cells
  for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_s;
    if (k == 0) begin : g_first
      assign left_e = '0;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = cells[k-1];
      assign left_s = swaps[k-1];
    end
    if (k == MAX_CANDIDATES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_more
      assign right_e = cells[k+1];
    end
    gbso_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_BITS'(k)),
      .left_entry (left_e),
      .right_entry(right_e),
      .wrap_entry (cells[0]),
      .left_swap  (left_s),
      .entry      (cells[k]),
      .swap_right (swaps[k])
    );
  end

  gbso_overlap u_overlap (
    .clk  (clk),
    .kept (kept),
    .cand (cells[0]),
    .ratio(ratio),
    .hit  (hit)
  );

  // row command
  always_comb begin
    ctl          = '0;
    ctl.cmd      = CMD_HOLD;
    ctl.cnt      = cnt;
    ctl.parity   = t_cnt[0];
    ctl.mode     = (state == S_SSORT) ? MODE_SCORE : order_mode;
    ctl.load.x       = in_data.box_x;
    ctl.load.y       = in_data.box_y;
    ctl.load.w       = in_data.box_w;
    ctl.load.h       = in_data.box_h;
    ctl.load.score   = in_data.match_score;
    ctl.load.pattern = in_data.pattern_number;
    ctl.load.thresh  = in_data.keep_threshold;
    ctl.load.area    = AREA_BITS'(in_data.box_w * in_data.box_h);
    ctl.load.mark    = 1'b0;
    case (state)
      S_IDLE:     if (accept && is_add && cnt < CNT_BITS'(MAX_CANDIDATES)) ctl.cmd = CMD_LOAD;
      S_SSORT:    ctl.cmd = CMD_SORT;
      S_SUP_HEAD: if (i_cnt != n_run) ctl.cmd = CMD_ROT;
      S_SUP_STEP: if (t_cnt >= n_run - i_cnt) ctl.cmd = CMD_ROT;
      S_E3:       if (hit) ctl.cmd = CMD_MARK;
      S_E4:       ctl.cmd = CMD_ROT;
      S_CMP:      if (t_cnt != n_run) ctl.cmd = head_keep ? CMD_ROT : CMD_DROP;
      S_OSORT:    ctl.cmd = CMD_SORT;
      S_EMIT:     if (load_out) ctl.cmd = CMD_DROP;
      default:    ctl.cmd = CMD_HOLD;
    endcase
  end

  // sequencer, registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      ovf        <= 1'b0;
      ratio      <= RATIO_RESET;
      order_mode <= MODE_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATIO: ratio <= cfg_data;
          CFG_MODE:  order_mode <= cfg_data[MODE_BITS-1:0];
          default:   ;
        endcase
      end
      if (emit_now) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_add) begin
              if (cnt < CNT_BITS'(MAX_CANDIDATES)) cnt <= cnt + CNT_BITS'(1);
              else ovf <= 1'b1;
            end
            if (in_data.opcode == OP_ADD_PROC || in_data.opcode == OP_PROC) state <= S_PROC;
          end
        end
        S_PROC: begin
          t_cnt <= '0;
          i_cnt <= '0;
          n_run <= cnt;
          if (ratio != '0 && cnt > CNT_BITS'(1)) state <= S_SSORT;
          else state <= S_CMP;
        end
        S_SSORT: begin
          t_cnt <= t_cnt + CNT_BITS'(1);
          if (t_cnt == n_run - CNT_BITS'(1)) begin
            i_cnt <= '0;
            state <= S_SUP_HEAD;
          end
        end
        S_SUP_HEAD: begin
          if (i_cnt == n_run) begin
            t_cnt <= '0;
            state <= S_CMP;
          end else if (cells[0].mark) begin
            i_cnt <= i_cnt + CNT_BITS'(1);
          end else begin
            kept  <= cells[0];
            t_cnt <= CNT_BITS'(1);
            state <= S_SUP_STEP;
          end
        end
        S_SUP_STEP: begin
          if (t_cnt == n_run) begin
            i_cnt <= i_cnt + CNT_BITS'(1);
            state <= S_SUP_HEAD;
          end else if (t_cnt < n_run - i_cnt) begin
            state <= S_E1;
          end else begin
            t_cnt <= t_cnt + CNT_BITS'(1);
          end
        end
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: begin
          t_cnt <= t_cnt + CNT_BITS'(1);
          state <= S_SUP_STEP;
        end
        S_CMP: begin
          if (t_cnt == n_run) begin
            t_cnt <= '0;
            if (cnt > CNT_BITS'(1) && (order_mode inside {[MODE_XY:MODE_AREA]}))
              state <= S_OSORT;
            else if (cnt == '0) state <= S_EMPTY;
            else state <= S_EMIT;
          end else begin
            t_cnt <= t_cnt + CNT_BITS'(1);
            if (!head_keep) cnt <= cnt - CNT_BITS'(1);
          end
        end
        S_OSORT: begin
          t_cnt <= t_cnt + CNT_BITS'(1);
          if (t_cnt == cnt - CNT_BITS'(1)) state <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            out_data.out_x       <= cells[0].x;
            out_data.out_y       <= cells[0].y;
            out_data.out_w       <= cells[0].w;
            out_data.out_h       <= cells[0].h;
            out_data.out_score   <= cells[0].score;
            out_data.out_pattern <= cells[0].pattern;
            out_data.is_last     <= (cnt == CNT_BITS'(1));
            out_data.is_empty    <= 1'b0;
            out_data.overflowed  <= ovf;
            cnt                  <= cnt - CNT_BITS'(1);
            if (cnt == CNT_BITS'(1)) begin
              ovf   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (load_out) begin
            out_data <= {{(4 * COORD_BITS + SCORE_BITS + PAT_BITS){1'b0}}, 1'b1, 1'b1, ovf};
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(MAX_CANDIDATES))
    else $error("candidate count above capacity");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> cnt != '0)
    else $error("emit step with empty row");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && load_out) |=> cnt == $past(cnt) - CNT_BITS'(1))
    else $error("emit did not consume one entry");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_empty) |-> out_data.is_last)
    else $error("empty result not marked last");

endmodule

>>> rtl/gbso_cell.sv
// one cell of the candidate row: holds an entry, swaps, shifts or rotates with neighbors
module gbso_cell import gbso_pkg::*; (
  input  logic                clk,
  input  ctl_t                ctl,
  input  logic [IDX_BITS-1:0] idx,
  input  entry_t              left_entry,
  input  entry_t              right_entry,
  input  entry_t              wrap_entry,
  input  logic                left_swap,
  output entry_t              entry,
  output logic                swap_right
);

  logic [CNT_BITS-1:0] pos;
  logic [CNT_BITS-1:0] pos_up;
  logic                is_left;

  assign pos    = CNT_BITS'(idx);
  assign pos_up = pos + CNT_BITS'(1);

  // left member of an active compare pair this round
  assign is_left    = (idx[0] == ctl.parity) && (pos_up < ctl.cnt);
  assign swap_right = (ctl.cmd == CMD_SORT) && is_left &&
                      goes_before(right_entry, entry, ctl.mode);

  // entry update
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        if (pos == ctl.cnt) entry <= ctl.load;
      end
      CMD_SORT: begin
        if (swap_right) entry <= right_entry;
        else if (left_swap) entry <= left_entry;
      end
      CMD_ROT: begin
        if (pos_up == ctl.cnt) entry <= wrap_entry;
        else if (pos_up < ctl.cnt) entry <= right_entry;
      end
      CMD_DROP: begin
        if (pos_up < ctl.cnt) entry <= right_entry;
      end
      CMD_MARK: begin
        if (idx == '0) entry.mark <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/gbso_overlap.sv
// pipelined overlap test of a candidate against the kept box
module gbso_overlap import gbso_pkg::*; (
  input  logic                  clk,
  input  entry_t                kept,
  input  entry_t                cand,
  input  logic [RATIO_BITS-1:0] ratio,
  output logic                  hit
);

  localparam int END_BITS = COORD_BITS + 1;
  localparam int OV_BITS  = 2 * END_BITS;
  localparam int RA_BITS  = RATIO_BITS + AREA_BITS;
  localparam int CMP_BITS = OV_BITS + FRAC_BITS;

  logic [END_BITS-1:0]  x1, y1, x2, y2, ea, eb, fa, fb;
  logic [END_BITS-1:0]  dx, dy;
  logic [AREA_BITS-1:0] area;
  logic [OV_BITS-1:0]   ov;
  logic [RA_BITS-1:0]   ra;
  logic                 area_nz;

  // intersection extents
  always_comb begin
    x1 = (kept.x > cand.x) ? END_BITS'(kept.x) : END_BITS'(cand.x);
    y1 = (kept.y > cand.y) ? END_BITS'(kept.y) : END_BITS'(cand.y);
    ea = END_BITS'(kept.x) + END_BITS'(kept.w);
    eb = END_BITS'(cand.x) + END_BITS'(cand.w);
    fa = END_BITS'(kept.y) + END_BITS'(kept.h);
    fb = END_BITS'(cand.y) + END_BITS'(cand.h);
    x2 = (ea < eb) ? ea : eb;
    y2 = (fa < fb) ? fa : fb;
  end

  // stage one: side lengths, stage two: products
  always_ff @(posedge clk) begin
    dx      <= (x2 > x1) ? (x2 - x1) : '0;
    dy      <= (y2 > y1) ? (y2 - y1) : '0;
    area    <= cand.area;
    ov      <= OV_BITS'(dx * dy);
    ra      <= RA_BITS'(ratio * area);
    area_nz <= (area != '0);
  end

  assign hit = area_nz && ({ov, FRAC_BITS'(0)} >= CMP_BITS'(ra));

endmodule

>>> test/tb_greedy_box_suppress_and_order_top.sv
// testbench for the box suppression and ordering block: directed, register, pressure and random tests
`timescale 1ns / 100ps

module tb_greedy_box_suppress_and_order_top;
  import gbso_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 40;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_t                      in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_RATIO;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  greedy_box_suppress_and_order_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  in_t                  stored_boxes[MAX_CANDIDATES];
  int                   stored_count;
  bit                   dropped_any;
  logic [RATIO_BITS-1:0] ratio_q;
  logic [MODE_BITS-1:0]  mode_q;
  out_t                 expected_boxes[$];

  int  mismatch_count;
  int  cycle_count;
  bit  no_gaps;
  bit  hold_sink;

  // true when candidate a is emitted ahead of candidate b
  function automatic bit ranks_ahead(in_t a, in_t b, logic [MODE_BITS-1:0] m);
    longint unsigned area_a, area_b;
    area_a = longint'(a.box_w) * a.box_h;
    area_b = longint'(b.box_w) * b.box_h;
    case (m)
      MODE_XY:    return (a.box_x != b.box_x) ? (a.box_x < b.box_x) : (a.box_y < b.box_y);
      MODE_YX:    return (a.box_y != b.box_y) ? (a.box_y < b.box_y) : (a.box_x < b.box_x);
      MODE_SCORE: return a.match_score > b.match_score;
      MODE_AREA:  return (area_a != area_b) ? (area_a > area_b)
                                            : (a.match_score > b.match_score);
      default:    return 1'b0;
    endcase
  endfunction

  // stable insertion sort of the index list
  function automatic void order_list(ref int idx[$], input logic [MODE_BITS-1:0] m);
    int key, j;
    for (int i = 1; i < idx.size(); i++) begin
      key = idx[i];
      j = i;
      while (j > 0 && ranks_ahead(stored_boxes[key], stored_boxes[idx[j-1]], m)) begin
        idx[j] = idx[j-1];
        j--;
      end
      idx[j] = key;
    end
  endfunction

  function automatic longint unsigned intersection(in_t a, in_t b);
    int unsigned x1, y1, x2, y2;
    x1 = (a.box_x > b.box_x) ? a.box_x : b.box_x;
    y1 = (a.box_y > b.box_y) ? a.box_y : b.box_y;
    x2 = ((a.box_x + 32'(a.box_w)) < (b.box_x + 32'(b.box_w))) ?
         (a.box_x + 32'(a.box_w)) : (b.box_x + 32'(b.box_w));
    y2 = ((a.box_y + 32'(a.box_h)) < (b.box_y + 32'(b.box_h))) ?
         (a.box_y + 32'(a.box_h)) : (b.box_y + 32'(b.box_h));
    if (x2 <= x1 || y2 <= y1) return 0;
    return longint'(x2 - x1) * longint'(y2 - y1);
  endfunction

  // sort, suppress, threshold, order and queue the results of one run
  function automatic void run_suppression();
    int idx[$], kept[$], passed[$];
    bit gone[MAX_CANDIDATES];
    longint unsigned area;
    out_t r;
    for (int i = 0; i < stored_count; i++) begin
      idx = {idx, i};
      gone[i] = 1'b0;
    end
    if (ratio_q != 0 && stored_count > 1) begin
      order_list(idx, MODE_SCORE);
      for (int i = 0; i < idx.size(); i++) begin
        if (gone[i]) continue;
        kept = {kept, idx[i]};
        for (int j = i + 1; j < idx.size(); j++) begin
          if (gone[j]) continue;
          area = longint'(stored_boxes[idx[j]].box_w) * stored_boxes[idx[j]].box_h;
          if (area > 0 && (intersection(stored_boxes[idx[i]], stored_boxes[idx[j]]) << 15)
              >= longint'(ratio_q) * area)
            gone[j] = 1'b1;
        end
      end
      idx = kept;
    end
    foreach (idx[i])
      if (stored_boxes[idx[i]].match_score >= stored_boxes[idx[i]].keep_threshold)
        passed = {passed, idx[i]};
    order_list(passed, mode_q);
    if (passed.size() == 0) begin
      r = '0;
      r.is_last = 1'b1;
      r.is_empty = 1'b1;
      r.overflowed = dropped_any;
      expected_boxes = {expected_boxes, r};
    end else begin
      foreach (passed[i]) begin
        r.out_x       = stored_boxes[passed[i]].box_x;
        r.out_y       = stored_boxes[passed[i]].box_y;
        r.out_w       = stored_boxes[passed[i]].box_w;
        r.out_h       = stored_boxes[passed[i]].box_h;
        r.out_score   = stored_boxes[passed[i]].match_score;
        r.out_pattern = stored_boxes[passed[i]].pattern_number;
        r.is_last     = (i == passed.size() - 1);
        r.is_empty    = 1'b0;
        r.overflowed  = dropped_any;
        expected_boxes = {expected_boxes, r};
      end
    end
    stored_count = 0;
    dropped_any = 1'b0;
  endfunction

  function automatic void store_candidate(in_t it);
    if (stored_count >= MAX_CANDIDATES) dropped_any = 1'b1;
    else begin
      stored_boxes[stored_count] = it;
      stored_count++;
    end
  endfunction

  function automatic void predict(in_t it);
    case (it.opcode)
      OP_ADD: store_candidate(it);
      OP_ADD_PROC: begin
        store_candidate(it);
        run_suppression();
      end
      OP_PROC: run_suppression();
      default: ;
    endcase
  endfunction

  // send one transaction and update the predictor when it is accepted
  task automatic send_item(in_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RATIO) ratio_q = val;
    else mode_q = val[MODE_BITS-1:0];
  endtask

  // box near a center so that suppression has something to do
  function automatic in_t near_box(logic [1:0] op, int cx, int cy, int spread);
    in_t it;
    it.opcode         = op;
    it.box_x          = 12'(cx + $urandom_range(0, spread));
    it.box_y          = 12'(cy + $urandom_range(0, spread));
    it.box_w          = 12'($urandom_range(0, 40));
    it.box_h          = 12'($urandom_range(0, 40));
    it.match_score    = 16'($urandom_range(0, 32768));
    it.pattern_number = 8'($urandom);
    it.keep_threshold = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32768))
                                                    : 16'($urandom_range(0, 8000));
    if ($urandom_range(0, 9) == 0) begin
      it.box_x = 12'($urandom);
      it.box_w = 12'($urandom);
      it.box_h = 12'($urandom);
      it.match_score = 16'($urandom);
      it.keep_threshold = 16'($urandom);
    end
    return it;
  endfunction

  function automatic in_t make_box(logic [1:0] op, int x, int y, int w, int h,
                                   int score, int pat, int thr);
    in_t it;
    it.opcode = op;
    it.box_x = 12'(x);
    it.box_y = 12'(y);
    it.box_w = 12'(w);
    it.box_h = 12'(h);
    it.match_score = 16'(score);
    it.pattern_number = 8'(pat);
    it.keep_threshold = 16'(thr);
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_boxes.size() == 0) begin
        $error("result with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_boxes.pop_front();
        if (out_data !== want) mismatch_count++;
        if (out_data.out_x !== want.out_x)
          $error("out_x exp %0d got %0d", want.out_x, out_data.out_x);
        if (out_data.out_y !== want.out_y)
          $error("out_y exp %0d got %0d", want.out_y, out_data.out_y);
        if (out_data.out_w !== want.out_w)
          $error("out_w exp %0d got %0d", want.out_w, out_data.out_w);
        if (out_data.out_h !== want.out_h)
          $error("out_h exp %0d got %0d", want.out_h, out_data.out_h);
        if (out_data.out_score !== want.out_score)
          $error("out_score exp %0d got %0d", want.out_score, out_data.out_score);
        if (out_data.out_pattern !== want.out_pattern)
          $error("out_pattern exp %0d got %0d", want.out_pattern, out_data.out_pattern);
        if (out_data.is_last !== want.is_last)
          $error("is_last exp %0d got %0d", want.is_last, out_data.is_last);
        if (out_data.is_empty !== want.is_empty)
          $error("is_empty exp %0d got %0d", want.is_empty, out_data.is_empty);
        if (out_data.overflowed !== want.overflowed)
          $error("overflowed exp %0d got %0d", want.overflowed, out_data.overflowed);
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  initial begin
    int stall;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (40000) @(posedge clk);
        hold_sink = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && !hold_sink);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // extremes, special cases and every operation
  task automatic test_directed();
    send_item(make_box(OP_PROC, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_box(OP_ADD_PROC, 4095, 4095, 4095, 4095, 65535, 255, 0));
    send_item(make_box(OP_ADD, 10, 10, 20, 20, 30000, 1, 100));
    send_item(make_box(OP_ADD, 12, 12, 20, 20, 20000, 2, 100));
    send_item(make_box(OP_ADD, 500, 500, 0, 30, 32768, 3, 100));
    send_item(make_box(OP_ADD, 505, 505, 10, 10, 32768, 4, 100));
    send_item(make_box(OP_ADD, 900, 900, 5, 5, 5000, 5, 6000));
    send_item(make_box(OP_ADD, 3, 3000, 40, 2, 5000, 6, 5000));
    send_item(make_box(OP_NOP, 4095, 4095, 4095, 4095, 65535, 255, 65535));
    send_item(make_box(OP_ADD_PROC, 2000, 0, 1, 4095, 0, 170, 65535));
    send_item(make_box(OP_ADD, 100, 100, 8, 8, 100, 7, 0));
    send_item(make_box(OP_ADD, 100, 100, 8, 8, 100, 8, 0));
    send_item(make_box(OP_PROC, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  // walk the registers through their extremes with a short set each
  task automatic test_registers();
    logic [CFG_DATA_BITS-1:0] ratios[5] = '{16'd0, 16'd1, 16'd32768, 16'd65535, RATIO_RESET};
    for (int k = 0; k < 8; k++) begin
      write_reg(CFG_MODE, CFG_DATA_BITS'(k));
      write_reg(CFG_RATIO, ratios[k % 5]);
      for (int i = 0; i < 5; i++) send_item(near_box(OP_ADD, 200, 200, 30));
      send_item(near_box(OP_ADD_PROC, 200, 200, 30));
      wait_drained();
    end
  endtask

  // full store with drops, receiver held off while adds keep coming
  task automatic test_backpressure();
    write_reg(CFG_RATIO, 16'd8192);
    write_reg(CFG_MODE, CFG_DATA_BITS'(MODE_AREA));
    hold_sink = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 66; i++) send_item(near_box(OP_ADD, 50, 50, 3000));
    send_item(near_box(OP_PROC, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_item(near_box(OP_ADD, 60, 60, 20));
    send_item(near_box(OP_ADD_PROC, 60, 60, 20));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // random sets in phases, each with its own settings
  task automatic test_random();
    int sent, len, cx, cy;
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_RATIO, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 32768)));
      write_reg(CFG_MODE, CFG_DATA_BITS'($urandom_range(0, 7)));
      no_gaps = (phase == 2);
      while (sent < (phase + 1) * 45) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        cx = $urandom_range(0, 4000);
        cy = $urandom_range(0, 4000);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) send_item(near_box(OP_NOP, cx, cy, 60));
          send_item(near_box((i == len - 1 && $urandom_range(0, 1)) ? OP_ADD_PROC : OP_ADD,
                             cx, cy, 60));
          sent++;
        end
        if (stored_count != 0) send_item(near_box(OP_PROC, cx, cy, 60));
      end
      wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    stored_count = 0;
    dropped_any = 1'b0;
    ratio_q = RATIO_RESET;
    mode_q = MODE_NONE;
    mismatch_count = 0;
    cycle_count = 0;
    no_gaps = 1'b0;
    hold_sink = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
